### sv/lav_pkg.sv
// Shared format and latency constants of the look-at view matrix pipeline.
package lav_pkg;

  // Fraction bits of a unit axis entry (Q2.30)
  localparam int UNIT_FRAC = 30;

  // Bit steps of the square root and of each quotient
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;

  // Normalize unit: six front stages, root, numerator, divide, output
  localparam int NORM_LAT = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  // Whole block: input, dir norm, cross, right norm, five back stages
  localparam int PIPE_LAT = 1 + NORM_LAT + 2 + NORM_LAT + 5;

endpackage

### sv/look_at_view_matrix.sv
// Top level: look-at camera view matrix, fully pipelined.
//
//  channel  dir  transaction        payload
//  s_axis   in   eye/target/up      9 x 32-bit signed Q16.16
//  m_axis   out  view matrix        9 x Q2.30 rotation, 3 x 33-bit translation
//
// One transaction enters per cycle while m_axis is not stalled; most pipeline stages
// lie in the two normalize units (32-step root and 31-step divide each).
// Reset clears only the valid bits of the pipeline.
// A stall on m_axis freezes the whole pipeline; s_axis_tready follows it
// in the same cycle, so nothing is dropped or repeated.
module look_at_view_matrix (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // right_x/y/z, upward_x/y/z, dir_x/y/z (32 each), trans_right, trans_up,
  // trans_dir (33 each), 5 zero bits
  output logic [391:0] m_axis_tdata
);

  localparam int NL  = lav_pkg::NORM_LAT;
  localparam int LAT = lav_pkg::PIPE_LAT;
  localparam int UF  = lav_pkg::UNIT_FRAC;

  // Round a Q4.60 cross term to Q2.30, halves away from zero, clamp to one
  function automatic logic signed [31:0] round_unit(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [33:0] r;
    mag = x[63] ? 64'(-x) : 64'(x);
    r   = 34'((mag + (64'd1 << (UF - 1))) >> UF);
    if (r > (34'd1 << UF)) r = 34'd1 << UF;
    return x[63] ? -$signed(32'(r)) : $signed(32'(r));
  endfunction

  // Round a dot product by 30 bits, negate, saturate to 33 bits
  function automatic logic signed [32:0] trans_val(input logic signed [65:0] x);
    logic [65:0] mag;
    logic [35:0] r;
    mag = x[65] ? 66'(-x) : 66'(x);
    r   = 36'((mag + (66'd1 << (UF - 1))) >> UF);
    if (x[65]) begin
      return (r > 36'hFFFFFFFF) ? 33'sh0FFFFFFFF : $signed(33'(r));
    end else begin
      return (r > 36'h100000000) ? 33'sh100000000 : -$signed(33'(r));
    end
  endfunction

  logic en;
  logic [LAT-1:0] vld_q;

  // Advance when the output register is empty or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // Input stage: capture eye and up, form eye - target
  logic signed [31:0] eye1_q [3];
  logic signed [31:0] up1_q [3];
  logic signed [32:0] d1_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        eye1_q[k] <= $signed(s_axis_tdata[32*k +: 32]);
        up1_q[k]  <= $signed(s_axis_tdata[192 + 32*k +: 32]);
        d1_q[k]   <= 33'($signed(s_axis_tdata[32*k +: 32]))
                   - 33'($signed(s_axis_tdata[96 + 32*k +: 32]));
      end
    end
  end

  // Direction axis
  logic signed [31:0] dir_n [3];

  lav_norm #(.W(33)) u_dir_norm (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (d1_q),
    .unit_o (dir_n)
  );

  // Hold up, eye and dir until their partners come out of the normalizers
  logic signed [31:0] up_dl_q  [NL][3];
  logic signed [31:0] eye_dl_q [2*NL+2][3];
  logic signed [31:0] dir_dl_q [NL+2][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      up_dl_q[0]  <= up1_q;
      eye_dl_q[0] <= eye1_q;
      dir_dl_q[0] <= dir_n;
      for (int i = 1; i < NL; i++) up_dl_q[i] <= up_dl_q[i-1];
      for (int i = 1; i < 2*NL+2; i++) eye_dl_q[i] <= eye_dl_q[i-1];
      for (int i = 1; i < NL+2; i++) dir_dl_q[i] <= dir_dl_q[i-1];
    end
  end

  // Cross up x dir: products, then differences
  logic signed [63:0] p2_q [6];
  logic signed [63:0] rc3_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q[0] <= up_dl_q[NL-1][1] * dir_n[2];
      p2_q[1] <= up_dl_q[NL-1][2] * dir_n[1];
      p2_q[2] <= up_dl_q[NL-1][2] * dir_n[0];
      p2_q[3] <= up_dl_q[NL-1][0] * dir_n[2];
      p2_q[4] <= up_dl_q[NL-1][0] * dir_n[1];
      p2_q[5] <= up_dl_q[NL-1][1] * dir_n[0];
      for (int k = 0; k < 3; k++) rc3_q[k] <= p2_q[2*k] - p2_q[2*k+1];
    end
  end

  // Right axis
  logic signed [31:0] right_n [3];

  lav_norm #(.W(64)) u_right_norm (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (rc3_q),
    .unit_o (right_n)
  );

  // Cross dir x right products
  logic signed [63:0] p4_q [6];
  logic signed [31:0] right4_q [3];
  logic signed [31:0] dir4_q [3];
  logic signed [31:0] eye4_q [3];
  logic signed [31:0] dir_a [3];

  assign dir_a = dir_dl_q[NL+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_q[0]  <= dir_a[1] * right_n[2];
      p4_q[1]  <= dir_a[2] * right_n[1];
      p4_q[2]  <= dir_a[2] * right_n[0];
      p4_q[3]  <= dir_a[0] * right_n[2];
      p4_q[4]  <= dir_a[0] * right_n[1];
      p4_q[5]  <= dir_a[1] * right_n[0];
      right4_q <= right_n;
      dir4_q   <= dir_a;
      eye4_q   <= eye_dl_q[2*NL+1];
    end
  end

  // Round the true up axis
  logic signed [31:0] upw5_q [3];
  logic signed [31:0] right5_q [3];
  logic signed [31:0] dir5_q [3];
  logic signed [31:0] eye5_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) upw5_q[k] <= round_unit(p4_q[2*k] - p4_q[2*k+1]);
      right5_q <= right4_q;
      dir5_q   <= dir4_q;
      eye5_q   <= eye4_q;
    end
  end

  // Dot products of each axis with eye
  logic signed [63:0] pd6_q [3][3];
  logic signed [31:0] right6_q [3];
  logic signed [31:0] upw6_q [3];
  logic signed [31:0] dir6_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pd6_q[0][k] <= right5_q[k] * eye5_q[k];
        pd6_q[1][k] <= upw5_q[k] * eye5_q[k];
        pd6_q[2][k] <= dir5_q[k] * eye5_q[k];
      end
      right6_q <= right5_q;
      upw6_q   <= upw5_q;
      dir6_q   <= dir5_q;
    end
  end

  logic signed [65:0] sum7_q [3];
  logic signed [31:0] right7_q [3];
  logic signed [31:0] upw7_q [3];
  logic signed [31:0] dir7_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        sum7_q[a] <= 66'(pd6_q[a][0]) + 66'(pd6_q[a][1]) + 66'(pd6_q[a][2]);
      end
      right7_q <= right6_q;
      upw7_q   <= upw6_q;
      dir7_q   <= dir6_q;
    end
  end

  // Output register
  logic signed [31:0] right8_q [3];
  logic signed [31:0] upw8_q [3];
  logic signed [31:0] dir8_q [3];
  logic signed [32:0] tr8_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      right8_q <= right7_q;
      upw8_q   <= upw7_q;
      dir8_q   <= dir7_q;
      for (int a = 0; a < 3; a++) tr8_q[a] <= trans_val(sum7_q[a]);
    end
  end

  assign m_axis_tdata = {5'd0, tr8_q[2], tr8_q[1], tr8_q[0],
                         dir8_q[2], dir8_q[1], dir8_q[0],
                         upw8_q[2], upw8_q[1], upw8_q[0],
                         right8_q[2], right8_q[1], right8_q[0]};

  // A held output must hold off new input
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // The dir_x rotation entry stays within one
  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> dir8_q[0] <= 32'sh40000000 && dir8_q[0] >= -32'sh40000000)
    else $error("dir_x out of unit range");

  // A zero direction leaves right and the dir translation zero
  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && dir8_q[0] == 0 && dir8_q[1] == 0 && dir8_q[2] == 0
    |-> right8_q[0] == 0 && right8_q[1] == 0 && right8_q[2] == 0 && tr8_q[2] == 0)
    else $error("zero direction gave nonzero axes");

  // A zero right axis leaves the true up axis and the right translation zero
  a_zero_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && right8_q[0] == 0 && right8_q[1] == 0 && right8_q[2] == 0
    |-> upw8_q[0] == 0 && upw8_q[1] == 0 && upw8_q[2] == 0 && tr8_q[0] == 0)
    else $error("zero right axis gave nonzero up axis");

endmodule

### sv/lav_norm.sv
// Pipelined 3-vector normalizer: prescale, root, three dividers.
module lav_norm #(
  parameter int W = 64
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] vec_i  [3],
  output logic signed [31:0]  unit_o [3]
);

  localparam int NG = (W + 7) / 8;
  localparam int OW = NG * 8;
  localparam int PW = $clog2(OW);
  localparam int SN = lav_pkg::SQRT_STEPS;
  localparam int DN = lav_pkg::DIV_STEPS;

  // Stage 1: sign and magnitude
  logic [W-1:0] m1_q [3];
  logic [2:0]   neg1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        neg1_q[k] <= vec_i[k][W-1];
        m1_q[k]   <= vec_i[k][W-1] ? W'(-vec_i[k]) : W'(vec_i[k]);
      end
    end
  end

  // Stage 2: leading one of each byte of the OR of all magnitudes
  logic [OW-1:0] orv;
  logic [NG-1:0] gnz_d, gnz2_q;
  logic [2:0]    gpos_d [NG];
  logic [2:0]    gpos2_q [NG];
  logic [W-1:0]  m2_q [3];
  logic [2:0]    neg2_q;

  always_comb begin
    orv = OW'(m1_q[0] | m1_q[1] | m1_q[2]);
    for (int g = 0; g < NG; g++) begin
      gnz_d[g]  = |orv[g*8 +: 8];
      gpos_d[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (orv[g*8 + b]) gpos_d[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gnz2_q  <= gnz_d;
      gpos2_q <= gpos_d;
      m2_q    <= m1_q;
      neg2_q  <= neg1_q;
    end
  end

  // Stage 3: pick the highest nonzero byte
  logic [PW-1:0] pos_d, pos3_q;
  logic          zero_d, zero3_q;
  logic [W-1:0]  m3_q [3];
  logic [2:0]    neg3_q;

  always_comb begin
    pos_d  = '0;
    zero_d = 1'b1;
    for (int g = 0; g < NG; g++) begin
      if (gnz2_q[g]) begin
        pos_d  = PW'(g * 8) + PW'(gpos2_q[g]);
        zero_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos3_q  <= pos_d;
      zero3_q <= zero_d;
      m3_q    <= m2_q;
      neg3_q  <= neg2_q;
    end
  end

  // Stage 4: shift so the largest magnitude lies in [2^29, 2^30)
  logic [29:0] m4_d [3];
  logic [29:0] m4_q [3];
  logic [2:0]  neg4_q;
  logic        zero4_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (pos3_q >= PW'(29)) begin
        m4_d[k] = 30'(m3_q[k] >> (pos3_q - PW'(29)));
      end else begin
        m4_d[k] = 30'(m3_q[k] << (PW'(29) - pos3_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m4_q    <= m4_d;
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
    end
  end

  // Stage 5: squares
  logic [59:0] sq5_q [3];
  logic [29:0] m5_q [3];
  logic [2:0]  neg5_q;
  logic        zero5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) sq5_q[k] <= m4_q[k] * m4_q[k];
      m5_q    <= m4_q;
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
    end
  end

  // Stage 6: sum of squares
  logic [61:0] s6_q;
  logic [29:0] m6_q [3];
  logic [2:0]  neg6_q;
  logic        zero6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_q    <= 62'(sq5_q[0]) + 62'(sq5_q[1]) + 62'(sq5_q[2]);
      m6_q    <= m5_q;
      neg6_q  <= neg5_q;
      zero6_q <= zero5_q;
    end
  end

  // Square root, one result bit per stage
  logic [63:0] sx_in [SN];
  logic [63:0] sr_in [SN];
  logic [63:0] sx_d [SN];
  logic [63:0] sr_d [SN];
  logic [63:0] sx_q [SN];
  logic [63:0] sr_q [SN];
  logic [29:0] sm_q [SN][3];
  logic [2:0]  sneg_q [SN];
  logic        szero_q [SN];
  logic [63:0] bitv;
  logic [63:0] trial;

  always_comb begin
    sx_in[0] = 64'(s6_q);
    sr_in[0] = '0;
    for (int j = 1; j < SN; j++) begin
      sx_in[j] = sx_q[j-1];
      sr_in[j] = sr_q[j-1];
    end
    bitv  = '0;
    trial = '0;
    for (int j = 0; j < SN; j++) begin
      bitv  = 64'd1 << (2 * (SN - 1 - j));
      trial = sr_in[j] + bitv;
      if (sx_in[j] >= trial) begin
        sx_d[j] = sx_in[j] - trial;
        sr_d[j] = (sr_in[j] >> 1) + bitv;
      end else begin
        sx_d[j] = sx_in[j];
        sr_d[j] = sr_in[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q       <= sx_d;
      sr_q       <= sr_d;
      sm_q[0]    <= m6_q;
      sneg_q[0]  <= neg6_q;
      szero_q[0] <= zero6_q;
      for (int j = 1; j < SN; j++) begin
        sm_q[j]    <= sm_q[j-1];
        sneg_q[j]  <= sneg_q[j-1];
        szero_q[j] <= szero_q[j-1];
      end
    end
  end

  // Numerator stage: m * 2^30 + floor(L / 2)
  logic [30:0] len;
  logic [60:0] n7_q [3];
  logic [30:0] l7_q;
  logic [2:0]  neg7_q;
  logic        zero7_q;

  assign len = sr_q[SN-1][30:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        n7_q[k] <= 61'({sm_q[SN-1][k], 30'd0}) + 61'(len >> 1);
      end
      l7_q    <= len;
      neg7_q  <= sneg_q[SN-1];
      zero7_q <= szero_q[SN-1];
    end
  end

  // Restoring divide, one quotient bit per stage for each lane
  logic [30:0] dr_in [DN][3];
  logic [30:0] dq_in [DN][3];
  logic [30:0] dn_in [DN][3];
  logic [30:0] dl_in [DN];
  logic [30:0] dr_d [DN][3];
  logic [30:0] dq_d [DN][3];
  logic [30:0] dr_q [DN][3];
  logic [30:0] dq_q [DN][3];
  logic [30:0] dn_q [DN][3];
  logic [30:0] dl_q [DN];
  logic [2:0]  dneg_q [DN];
  logic        dzero_q [DN];
  logic [31:0] tr;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dr_in[0][k] = {1'b0, n7_q[k][60:31]};
      dq_in[0][k] = '0;
      dn_in[0][k] = n7_q[k][30:0];
    end
    dl_in[0] = l7_q;
    for (int i = 1; i < DN; i++) begin
      dr_in[i] = dr_q[i-1];
      dq_in[i] = dq_q[i-1];
      dn_in[i] = dn_q[i-1];
      dl_in[i] = dl_q[i-1];
    end
    tr = '0;
    for (int i = 0; i < DN; i++) begin
      for (int k = 0; k < 3; k++) begin
        tr = {dr_in[i][k], dn_in[i][k][DN-1-i]};
        if (tr >= {1'b0, dl_in[i]}) begin
          dr_d[i][k] = 31'(tr - {1'b0, dl_in[i]});
          dq_d[i][k] = {dq_in[i][k][29:0], 1'b1};
        end else begin
          dr_d[i][k] = tr[30:0];
          dq_d[i][k] = {dq_in[i][k][29:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dr_q       <= dr_d;
      dq_q       <= dq_d;
      dn_q       <= dn_in;
      dl_q       <= dl_in;
      dneg_q[0]  <= neg7_q;
      dzero_q[0] <= zero7_q;
      for (int i = 1; i < DN; i++) begin
        dneg_q[i]  <= dneg_q[i-1];
        dzero_q[i] <= dzero_q[i-1];
      end
    end
  end

  // Output stage: apply sign, force zero for a zero vector
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        if (dzero_q[DN-1]) begin
          unit_o[k] <= '0;
        end else if (dneg_q[DN-1][k]) begin
          unit_o[k] <= -$signed({1'b0, dq_q[DN-1][k]});
        end else begin
          unit_o[k] <= $signed({1'b0, dq_q[DN-1][k]});
        end
      end
    end
  end

endmodule
